// ----- rtl/next_fit_page_allocator_unit_defines.svh -----
// Assertion macros for the page allocator
`ifndef NEXT_FIT_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define NEXT_FIT_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NFPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define NFPA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NFPA_ASSERT(label, clk, rst_n, prop, msg)
`define NFPA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- rtl/nfpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpa_pkg
// Types and constants shared by the page allocator modules.
// ----------------------------------------------------------------------------
package nfpa_pkg;
    localparam int HEAP_PAGES = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_W     = $clog2(HEAP_PAGES);
    localparam int CNT_W      = $clog2(HEAP_PAGES + 1);
    localparam int SHIFT_W    = $clog2(PAGE_BYTES);

    localparam logic [1:0] ST_ALLOCATED    = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL   = 2'd1;
    localparam logic [1:0] ST_FREED        = 2'd2;
    localparam logic [1:0] ST_FREE_IGNORED = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_MARK, S_FIND, S_LAST, S_MOVE, S_CLEAR, S_DONE
    } state_t;

    // bitmap port request
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] addr;
        logic              wdata;
    } bm_req_t;

    // record port request
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [PAGE_W-1:0] wbase;
        logic [CNT_W-1:0]  wlen;
        logic [PAGE_W-1:0] raddr;
    } rec_req_t;
endpackage

// ----- rtl/next_fit_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_page_allocator_unit
// Next-fit bitmap page allocator with a record list for frees.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_axis  | in  | tdata: operation, request_bytes, release_address
// m_axis  | out | tdata: status, block_address, page_count
// cfg     | in  | heap_base
//
// After reset a sweep clears the bitmap page by page; no request is taken meanwhile.
// Allocate: the request is taken, the bitmap is scanned from the next-fit cursor
// (one bitmap read per cycle), then each page of the block is marked.
// Free: the live records are read in turn to find the block, the last record is
// moved into the freed slot, each page is cleared, then the result is posted.
// A posted result moves to the output register once that register is free or
// being read; the next request is taken while it waits there, and the input
// stalls while the result stage is full.
`include "next_fit_page_allocator_unit_defines.svh"
module next_fit_page_allocator_unit
    import nfpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] operation, [32:1] request_bytes, [64:33] release_address, zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] block_address, [44:34] page_count, zero pad
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    state_t state_reg, state_next;
    logic [31:0]       heap_base_reg;
    logic              sweep_reg, sweep_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;    // page / record index
    logic [CNT_W-1:0]  chk_reg, chk_next;    // visits, records or pages done
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  need_reg, need_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [PAGE_W-1:0] cursor_reg, cursor_next;
    logic              rv_reg, rv_next;      // read data valid for prev_reg
    logic [PAGE_W-1:0] prev_reg, prev_next;  // index whose read returns now
    logic [31:0]       addr_reg, addr_next;
    logic              op_reg, op_next;
    logic              ov_reg, ov_next;      // result stage full
    logic [47:0]       out_reg, out_next;
    logic              mv_reg, mv_next;      // output register full
    logic [47:0]       md_reg, md_next;

    bm_req_t  bm;
    rec_req_t rc;
    logic              bm_rd;
    logic [PAGE_W-1:0] rc_base;
    logic [CNT_W-1:0]  rc_len;

    nfpa_bitmap_ram u_bm (.clk(clk), .req(bm), .rdata(bm_rd));
    nfpa_record_ram u_rc (.clk(clk), .req(rc), .rbase(rc_base), .rlen(rc_len));

    logic [31:0] in_bytes;
    logic [32:0] pages_up;
    logic [31:0] rec_addr;
    logic [31:0] base_addr;
    assign in_bytes  = s_axis_tdata[32:1];
    assign pages_up  = ({1'b0, in_bytes} + 33'(PAGE_BYTES - 1)) >> SHIFT_W;
    assign rec_addr  = heap_base_reg + (32'(rc_base) << SHIFT_W);
    assign base_addr = heap_base_reg + (32'(start_reg) << SHIFT_W);

    assign s_axis_tready = (state_reg == S_IDLE) && !sweep_reg && !ov_reg;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;

    // output register: takes the posted result once it is free or being taken
    always_comb
    begin
        mv_next = mv_reg;
        md_next = md_reg;
        if (ov_reg && (!mv_reg || m_axis_tready))
        begin
            mv_next = 1'b1;
            md_next = out_reg;
        end
        else if (m_axis_tready)
            mv_next = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        idx_next = idx_reg; chk_next = chk_reg; run_next = run_reg;
        need_next = need_reg; start_next = start_reg; total_next = total_reg;
        cursor_next = cursor_reg; rv_next = 1'b0; prev_next = idx_reg;
        addr_next = addr_reg; op_next = op_reg; ov_next = ov_reg;
        out_next = out_reg;
        bm = '0; bm.addr = idx_reg;
        rc = '0; rc.raddr = idx_reg;
        if (ov_reg && (!mv_reg || m_axis_tready))
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (sweep_reg)
                begin
                    bm.we = 1'b1; bm.wdata = 1'b0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == PAGE_W'(HEAP_PAGES - 1))
                        sweep_next = 1'b0;
                end
                else if (s_axis_tvalid && s_axis_tready)
                begin
                    op_next = s_axis_tdata[0];
                    addr_next = s_axis_tdata[64:33];
                    chk_next = '0; run_next = '0;
                    if (s_axis_tdata[0] == OP_ALLOC)
                    begin
                        if (in_bytes == 32'd0 || pages_up > 33'(HEAP_PAGES)
                            || total_reg >= CNT_W'(HEAP_PAGES))
                        begin
                            out_next = {3'b0, CNT_W'(0), 32'd0, ST_ALLOC_FAIL};
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            need_next = CNT_W'(pages_up);
                            idx_next = cursor_reg;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        state_next = S_FIND;
                    end
                end
            end
            S_SCAN:
            begin
                // issue read of idx_reg, evaluate data of prev_reg
                if (chk_reg < CNT_W'(HEAP_PAGES))
                begin
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    chk_next = chk_reg + 1'b1;
                end
                if (rv_reg)
                begin
                    if (bm_rd || prev_reg == '0)
                        run_next = bm_rd ? '0 : CNT_W'(1);
                    else
                        run_next = run_reg + 1'b1;
                    if (!bm_rd && run_next == need_reg)
                    begin
                        start_next = PAGE_W'(prev_reg + 1'b1 - need_reg);
                        idx_next = PAGE_W'(prev_reg + 1'b1 - need_reg);
                        chk_next = '0;
                        rv_next = 1'b0;
                        state_next = S_MARK;
                    end
                end
                if (state_next == S_SCAN && !rv_reg && chk_reg == CNT_W'(HEAP_PAGES))
                begin
                    out_next = {3'b0, CNT_W'(0), 32'd0, ST_ALLOC_FAIL};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                bm.we = 1'b1; bm.wdata = 1'b1;
                idx_next = idx_reg + 1'b1;
                chk_next = chk_reg + 1'b1;
                if (chk_reg + 1'b1 == need_reg)
                begin
                    rc.we = 1'b1; rc.waddr = total_reg[PAGE_W-1:0];
                    rc.wbase = start_reg; rc.wlen = need_reg;
                    total_next = total_reg + 1'b1;
                    cursor_next = PAGE_W'(start_reg + need_reg);
                    out_next = {3'b0, need_reg, base_addr, ST_ALLOCATED};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                // chk_reg counts records read; idx_reg alone would wrap at a full list
                if (chk_reg < total_reg && !(rv_reg && rec_addr == addr_reg))
                begin
                    rv_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    chk_next = chk_reg + 1'b1;
                end
                if (rv_reg && rec_addr == addr_reg)
                begin
                    rv_next = 1'b0;
                    start_next = rc_base; need_next = rc_len;
                    idx_next = prev_reg;   // hole
                    total_next = total_reg - 1'b1;
                    state_next = S_LAST;
                end
                else if (!rv_reg && chk_reg >= total_reg)
                begin
                    out_next = {3'b0, CNT_W'(0), 32'd0, ST_FREE_IGNORED};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LAST:
            begin
                rc.raddr = total_reg[PAGE_W-1:0];
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                rc.we = 1'b1; rc.waddr = idx_reg;
                rc.wbase = rc_base; rc.wlen = rc_len;
                idx_next = start_reg; chk_next = '0;
                state_next = S_CLEAR;
                if (need_reg == '0)
                    state_next = S_DONE;
            end
            S_CLEAR:
            begin
                bm.we = 1'b1; bm.wdata = 1'b0;
                idx_next = idx_reg + 1'b1;
                chk_next = chk_reg + 1'b1;
                if (chk_reg + 1'b1 == need_reg || idx_reg == PAGE_W'(HEAP_PAGES - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                out_next = {3'b0, need_reg, base_addr, ST_FREED};
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; sweep_reg <= 1'b1; idx_reg <= '0;
            total_reg <= '0; cursor_reg <= '0; rv_reg <= 1'b0; ov_reg <= 1'b0;
            mv_reg <= 1'b0;
            heap_base_reg <= 32'h8000_0000;
        end
        else
        begin
            state_reg <= state_next; sweep_reg <= sweep_next; idx_reg <= idx_next;
            total_reg <= total_next; cursor_reg <= cursor_next;
            rv_reg <= rv_next; ov_reg <= ov_next;
            mv_reg <= mv_next;
            if (cfg_we)
                heap_base_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg <= chk_next; run_reg <= run_next; need_reg <= need_next;
        start_reg <= start_next; prev_reg <= prev_next; addr_reg <= addr_next;
        op_reg <= op_next; out_reg <= out_next; md_reg <= md_next;
    end

    `NFPA_ASSERT(a_no_take_busy, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !(state_reg == S_IDLE && sweep_reg), "request taken during sweep")
    `NFPA_ASSERT(a_total_range, clk, rst_n, total_reg <= CNT_W'(HEAP_PAGES), "record count overflow")
    `NFPA_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `NFPA_ASSERT(a_op_used, clk, rst_n, state_reg == S_MARK |-> op_reg == OP_ALLOC, "mark on free")
endmodule

// ----- rtl/nfpa_bitmap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpa_bitmap_ram
// Used-page bitmap, one bit per page, registered read, cleared by a sweep.
// ----------------------------------------------------------------------------
module nfpa_bitmap_ram
    import nfpa_pkg::*;
(
    input  logic    clk,
    input  bm_req_t req,
    output logic    rdata
);
    logic mem [HEAP_PAGES];

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.addr] <= req.wdata;
        rdata <= mem[req.addr];
    end
endmodule

// ----- rtl/nfpa_record_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpa_record_ram
// Block records (base page, length), one write and one read port.
// ----------------------------------------------------------------------------
module nfpa_record_ram
    import nfpa_pkg::*;
(
    input  logic              clk,
    input  rec_req_t          req,
    output logic [PAGE_W-1:0] rbase,
    output logic [CNT_W-1:0]  rlen
);
    logic [PAGE_W+CNT_W-1:0] mem [HEAP_PAGES];

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= {req.wbase, req.wlen};
        {rbase, rlen} <= mem[req.raddr];
    end
endmodule
